// File: design/pdds_pkg.sv
// Package for point_delta_direction_speed: payload types, states, constants, angle table.
`default_nettype none
package pdds_pkg;

    // Fixed field widths of the ports
    localparam int COORD_IN_W = 32;
    localparam int ANG_W      = 16;
    localparam int DIST_W     = 33;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath: operands are normalized so the larger magnitude reaches bit NORM_TOP
    localparam int NORM_TOP = 56;
    localparam int NW       = NORM_TOP + 1;
    localparam int CW       = 61;
    // Angle accumulator in 1/65536 degree
    localparam int ZW       = 26;
    localparam int ANG_LIMIT = 23040;
    localparam logic signed [ZW-1:0] DEG90 = ZW'(5898240);

    // Distance saturation value
    localparam logic [DIST_W-1:0] DIST_MAX = 33'd7439101575;

    // Square root: radicand, root and remainder widths
    localparam int SQ_IN_W  = 33;
    localparam int PW       = 2 * SQ_IN_W;
    localparam int SW       = 68;
    localparam int RTW      = SW / 2;
    localparam int RW       = RTW + 3;
    localparam int SQ_STEPS = SW / 2;

    typedef struct packed {
        logic                          cmd;
        logic [1:0]                    coord_count;
        logic signed [COORD_IN_W-1:0]  coord_x;
        logic signed [COORD_IN_W-1:0]  coord_y;
        logic signed [COORD_IN_W-1:0]  coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [ANG_W-1:0] azimuth;
        logic signed [ANG_W-1:0] elevation;
        logic [DIST_W-1:0]       distance;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_LOAD,
        S_NORM,
        S_QUAD,
        S_ROT,
        S_ANGLE,
        S_MAG,
        S_SQUARE,
        S_SQRT,
        S_FINISH
    } t_state;

    localparam logic CMD_POINT  = 1'b0;
    localparam logic CMD_REPEAT = 1'b1;

    // atan(2^-k) in 1/65536 degree, rounded to nearest
    function automatic logic [ZW-1:0] step_angle(input logic [4:0] k);
        logic [ZW-1:0] a;
        unique case (k)
            5'd0:    a = ZW'(2949120);
            5'd1:    a = ZW'(1740967);
            5'd2:    a = ZW'(919879);
            5'd3:    a = ZW'(466945);
            5'd4:    a = ZW'(234379);
            5'd5:    a = ZW'(117304);
            5'd6:    a = ZW'(58666);
            5'd7:    a = ZW'(29335);
            5'd8:    a = ZW'(14668);
            5'd9:    a = ZW'(7334);
            5'd10:   a = ZW'(3667);
            5'd11:   a = ZW'(1833);
            5'd12:   a = ZW'(917);
            5'd13:   a = ZW'(458);
            5'd14:   a = ZW'(229);
            5'd15:   a = ZW'(115);
            5'd16:   a = ZW'(57);
            5'd17:   a = ZW'(29);
            5'd18:   a = ZW'(14);
            5'd19:   a = ZW'(7);
            5'd20:   a = ZW'(4);
            5'd21:   a = ZW'(2);
            5'd22:   a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: design/point_delta_direction_speed.sv
// Top level: stores current/previous point, gives direction angles and length of their step.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  in        | input     | i_in_valid / o_in_ready | i_in_data  (pdds_pkg::t_in_item)
//  out       | output    | o_out_valid/ i_out_ready| o_out_data (pdds_pkg::t_out_item)
//  cfg       | input     | i_cfg_we (no wait)      | i_cfg_wdata (absolute_mode)
//
// A transaction runs from accept through both angles and the length before the next accept;
// each angle normalizes its operands, then rotates, and an angle of two zero operands skips
// the rotation and gives zero. The single CORDIC shift/add unit runs both arctangents in
// turn, then, unless a delta magnitude saturates the distance, the 33x33 multiplier forms
// three squares and a one-bit-per-cycle square root gives the length. o_in_ready is high
// only in idle; a finished result sits in the output register, so the next transaction can
// enter while it waits, and a second result stalls until it leaves. Synchronous active-low
// reset clears the points, absolute_mode and the output valid.
`default_nettype none
module point_delta_direction_speed #(
    parameter int COORD_WIDTH  = pdds_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = pdds_pkg::CORDIC_STEPS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  pdds_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pdds_pkg::t_out_item  o_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_wdata
);
    import pdds_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int IW = (COORD_WIDTH > COORD_IN_W) ? COORD_WIDTH : COORD_IN_W;
    localparam int MW = (DW > SQ_IN_W) ? DW : SQ_IN_W;
    localparam int KW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int CNTW = $clog2(SQ_STEPS);
    localparam logic signed [ZW:0] QMAX = (ZW+1)'(ANG_LIMIT);
    localparam logic signed [ZW:0] QMIN = -QMAX;

    // Registers
    t_state                        r_state, n_state;
    logic                          r_absolute_mode, n_absolute_mode;
    logic signed [COORD_WIDTH-1:0] r_cur [3];
    logic signed [COORD_WIDTH-1:0] n_cur [3];
    logic signed [COORD_WIDTH-1:0] r_prev [3];
    logic signed [COORD_WIDTH-1:0] n_prev [3];
    logic signed [DW-1:0]          r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic                          r_pass, n_pass;
    logic signed [CW-1:0]          r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0]          r_z, n_z;
    logic [NW-1:0]                 r_m, n_m;
    logic [KW-1:0]                 r_k, n_k;
    logic signed [ANG_W-1:0]       r_az, n_az, r_el, n_el;
    logic [PW-1:0]                 r_prod, n_prod;
    logic [SW-1:0]                 r_sum, n_sum;
    logic [1:0]                    r_sq, n_sq;
    logic [RW-1:0]                 r_rem, n_rem;
    logic [RTW-1:0]                r_root, n_root;
    logic [CNTW-1:0]               r_cnt, n_cnt;
    logic [DIST_W-1:0]             r_dist, n_dist;
    logic                          r_out_valid, n_out_valid;
    t_out_item                     r_out, n_out;

    // Combinational helpers
    logic [IW-1:0]                 ext [3];
    logic signed [CW-1:0]          x_in, y_in, ax, ay, xs, ys;
    logic [ZW-1:0]                 ang;
    logic signed [ZW:0]            zr, q, qc;
    logic [MW-1:0]                 am [3];
    logic                          sat;
    logic [SQ_IN_W-1:0]            opnd;
    logic [RW-1:0]                 rem_sh, trial;
    logic [RTW-1:0]                root_nx;
    logic                          in_acc, out_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;

    // Bring the 32-bit fields to the stored coordinate width
    assign ext[0] = IW'(i_in_data.coord_x);
    assign ext[1] = IW'(i_in_data.coord_y);
    assign ext[2] = IW'(i_in_data.coord_z);

    // Pick the operand pair of the current pass: azimuth (dx over dz), then elevation (dy over dx)
    always_comb begin
        if (!r_pass) begin
            y_in = {{(CW-DW){r_dx[DW-1]}}, r_dx};
            x_in = {{(CW-DW){r_dz[DW-1]}}, r_dz};
        end else begin
            y_in = {{(CW-DW){r_dy[DW-1]}}, r_dy};
            x_in = {{(CW-DW){r_dx[DW-1]}}, r_dx};
        end
        ax = x_in[CW-1] ? -x_in : x_in;
        ay = y_in[CW-1] ? -y_in : y_in;
    end

    // Shared CORDIC shifter and angle table
    assign xs  = r_x >>> r_k;
    assign ys  = r_y >>> r_k;
    assign ang = step_angle(5'(r_k));

    // Round to 1/128 degree, half up, and clamp
    always_comb begin
        zr = {r_z[ZW-1], r_z} + (ZW+1)'(256);
        q  = zr >>> 9;
        if (q > QMAX) begin
            qc = QMAX;
        end else if (q < QMIN) begin
            qc = QMIN;
        end else begin
            qc = q;
        end
    end

    // Delta magnitudes for saturation check and squaring
    always_comb begin
        am[0] = MW'($unsigned(r_dx[DW-1] ? -r_dx : r_dx));
        am[1] = MW'($unsigned(r_dy[DW-1] ? -r_dy : r_dy));
        am[2] = MW'($unsigned(r_dz[DW-1] ? -r_dz : r_dz));
        sat = (am[0] > MW'(DIST_MAX)) || (am[1] > MW'(DIST_MAX)) ||
              (am[2] > MW'(DIST_MAX));
        case (r_sq)
            2'd0:    opnd = am[0][SQ_IN_W-1:0];
            2'd1:    opnd = am[1][SQ_IN_W-1:0];
            2'd2:    opnd = am[2][SQ_IN_W-1:0];
            default: opnd = '0;
        endcase
    end

    // One square-root digit step
    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_sum[SW-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        root_nx = {r_root[RTW-2:0], (rem_sh >= trial)};
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state         = r_state;
        n_absolute_mode = r_absolute_mode;
        n_cur           = r_cur;
        n_prev          = r_prev;
        n_dx            = r_dx;
        n_dy            = r_dy;
        n_dz            = r_dz;
        n_pass          = r_pass;
        n_x             = r_x;
        n_y             = r_y;
        n_z             = r_z;
        n_m             = r_m;
        n_k             = r_k;
        n_az            = r_az;
        n_el            = r_el;
        n_prod          = r_prod;
        n_sum           = r_sum;
        n_sq            = r_sq;
        n_rem           = r_rem;
        n_root          = r_root;
        n_cnt           = r_cnt;
        n_dist          = r_dist;
        n_out           = r_out;
        n_out_valid     = r_out_valid && !out_acc;

        if (i_cfg_we) begin
            n_absolute_mode = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                // Shift points (prev 0 in absolute mode) on a point, then set leading coords
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_POINT) begin
                        for (int i = 0; i < 3; i++) begin
                            n_prev[i] = r_absolute_mode ? '0 : r_cur[i];
                            if (2'(i) < i_in_data.coord_count) begin
                                n_cur[i] = ext[i][COORD_WIDTH-1:0];
                            end
                        end
                    end
                    n_state = S_DELTA;
                end
            end
            S_DELTA: begin
                n_dx   = {r_cur[0][COORD_WIDTH-1], r_cur[0]} -
                         {r_prev[0][COORD_WIDTH-1], r_prev[0]};
                n_dy   = {r_cur[1][COORD_WIDTH-1], r_cur[1]} -
                         {r_prev[1][COORD_WIDTH-1], r_prev[1]};
                n_dz   = {r_cur[2][COORD_WIDTH-1], r_cur[2]} -
                         {r_prev[2][COORD_WIDTH-1], r_prev[2]};
                n_pass = 1'b0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_x = x_in;
                n_y = y_in;
                n_m = NW'(ax | ay);
                n_state = S_NORM;
            end
            S_NORM: begin
                // Scale up in coarse then fine steps until bit NORM_TOP is reached
                if (r_m == '0) begin
                    n_z     = '0;
                    n_state = S_ANGLE;
                end else if (r_m[NORM_TOP -: 16] == '0) begin
                    n_x = r_x <<< 16;
                    n_y = r_y <<< 16;
                    n_m = r_m << 16;
                end else if (r_m[NORM_TOP -: 4] == '0) begin
                    n_x = r_x <<< 4;
                    n_y = r_y <<< 4;
                    n_m = r_m << 4;
                end else if (!r_m[NORM_TOP]) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                    n_m = r_m << 1;
                end else begin
                    n_state = S_QUAD;
                end
            end
            S_QUAD: begin
                // Turn a left-half-plane vector by 90 degrees
                n_k = '0;
                if (r_x[CW-1]) begin
                    if (!r_y[CW-1]) begin
                        n_x = r_y;
                        n_y = -r_x;
                        n_z = DEG90;
                    end else begin
                        n_x = -r_y;
                        n_y = r_x;
                        n_z = -DEG90;
                    end
                end else begin
                    n_z = '0;
                end
                n_state = S_ROT;
            end
            S_ROT: begin
                // One vectoring step toward the x axis
                if (!r_y[CW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + $signed(ang);
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - $signed(ang);
                end
                n_k = r_k + 1'b1;
                if (r_k == KW'(CORDIC_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                if (!r_pass) begin
                    n_az    = qc[ANG_W-1:0];
                    n_pass  = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_el    = qc[ANG_W-1:0];
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                if (sat) begin
                    n_dist  = DIST_MAX;
                    n_state = S_FINISH;
                end else begin
                    n_sum   = '0;
                    n_prod  = '0;
                    n_sq    = '0;
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                // Square one magnitude a cycle, add the previous product
                n_prod = {{SQ_IN_W{1'b0}}, opnd} * {{SQ_IN_W{1'b0}}, opnd};
                n_sum  = r_sum + SW'(r_prod);
                n_sq   = r_sq + 2'd1;
                if (r_sq == 2'd3) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_sum  = r_sum << 2;
                n_root = root_nx;
                n_rem  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNTW'(SQ_STEPS - 1)) begin
                    n_dist  = (root_nx > RTW'(DIST_MAX)) ? DIST_MAX : root_nx[DIST_W-1:0];
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.azimuth   = r_az;
                    n_out.elevation = r_el;
                    n_out.distance  = r_dist;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and point state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_absolute_mode <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cur[i]  <= '0;
                r_prev[i] <= '0;
            end
        end else begin
            r_state         <= n_state;
            r_absolute_mode <= n_absolute_mode;
            r_out_valid     <= n_out_valid;
            r_cur           <= n_cur;
            r_prev          <= n_prev;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_dz   <= n_dz;
        r_pass <= n_pass;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_m    <= n_m;
        r_k    <= n_k;
        r_az   <= n_az;
        r_el   <= n_el;
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        r_dist <= n_dist;
        r_out  <= n_out;
    end

endmodule
`default_nettype wire

// File: test/tb_point_delta_direction_speed.sv
// Testbench for point_delta_direction_speed: random and directed points checked against a predictor.
`timescale 1ns / 100ps
module tb_point_delta_direction_speed;
    import pdds_pkg::*;

    localparam int  CYCLE_LIMIT   = 2_000_000;
    localparam int  PHASE_POINTS  = 275;
    localparam int  HOLD_AT       = 700;
    localparam int  HOLD_CYCLES   = 600;
    localparam int  SETTLE_CYCLES = 150;
    localparam int  ROT_STEPS     = CORDIC_STEPS_DEF;
    localparam logic signed [COORD_IN_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_IN_W-1:0] C_MAX = 32'sh7fff_ffff;
    localparam longint ROT_90 = 5898240;
    // atan(2^-k) in 1/65536 degree
    localparam longint ATAN_STEP [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;

    t_in_item   pending_points[$];
    t_out_item  expected_results[$];
    t_out_item  oldest_result;
    longint     cur_pt [0:2];
    longint     prev_pt [0:2];
    logic       abs_mode_model;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatches = 0;
    int         points_taken = 0;
    int         cycle_count = 0;
    int         hold_left;
    logic       hold_done;
    logic       in_fire = 1'b0;

    point_delta_direction_speed uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Vectoring CORDIC: angle of (den, num) in 1/128 degree
    function automatic logic signed [ANG_W-1:0] cordic_angle(input longint num,
                                                             input longint den);
        longint          x, y, z, t, xs, ys, q;
        longint unsigned m;
        int              sh;
        x = den;
        y = num;
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        m = magnitude(x) | magnitude(y);
        sh = 0;
        while (m < (64'd1 << NORM_TOP)) begin
            m = m << 1;
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        // fold the left half plane into the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = ROT_90;
            end else begin
                x = -y;
                y = t;
                z = -ROT_90;
            end
        end
        for (int k = 0; k < ROT_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[k];
            end
        end
        q = (z + 256) >>> 9;
        if (q > ANG_LIMIT)
            q = ANG_LIMIT;
        if (q < -ANG_LIMIT)
            q = -ANG_LIMIT;
        return ANG_W'(q);
    endfunction

    // Floor of the Euclidean length, saturated
    function automatic logic [DIST_W-1:0] step_length(input longint dx, input longint dy,
                                                      input longint dz);
        logic [63:0]  a, b, c, r, cand;
        logic [127:0] sum, sq;
        a = magnitude(dx);
        b = magnitude(dy);
        c = magnitude(dz);
        if (a > DIST_MAX || b > DIST_MAX || c > DIST_MAX)
            return DIST_MAX;
        sum = 128'(a) * 128'(a) + 128'(b) * 128'(b) + 128'(c) * 128'(c);
        r = '0;
        for (int bi = 34; bi >= 0; bi--) begin
            cand = r | (64'd1 << bi);
            sq = 128'(cand) * 128'(cand);
            if (sq <= sum)
                r = cand;
        end
        return (r > DIST_MAX) ? DIST_MAX : DIST_W'(r);
    endfunction

    // Advance the stored points for one transaction and return its direction and length
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item res;
        longint    dx, dy, dz;
        if (it.cmd == CMD_POINT) begin
            for (int i = 0; i < 3; i++)
                prev_pt[i] = abs_mode_model ? 0 : cur_pt[i];
            if (it.coord_count > 0)
                cur_pt[0] = longint'(it.coord_x);
            if (it.coord_count > 1)
                cur_pt[1] = longint'(it.coord_y);
            if (it.coord_count > 2)
                cur_pt[2] = longint'(it.coord_z);
        end
        dx = cur_pt[0] - prev_pt[0];
        dy = cur_pt[1] - prev_pt[1];
        dz = cur_pt[2] - prev_pt[2];
        res.azimuth = cordic_angle(dx, dz);
        res.elevation = cordic_angle(dy, dx);
        res.distance = step_length(dx, dy, dz);
        return res;
    endfunction

    function automatic logic signed [COORD_IN_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return C_MIN;
            2:       return C_MAX;
            3, 4:    return COORD_IN_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_point();
        t_in_item it;
        it.cmd = ($urandom_range(0, 4) == 0) ? CMD_REPEAT : CMD_POINT;
        it.coord_count = ($urandom_range(0, 1) == 0) ? 2'd3 : 2'($urandom_range(0, 3));
        it.coord_x = random_coord();
        it.coord_y = random_coord();
        it.coord_z = random_coord();
        return it;
    endfunction

    task automatic queue_point(input logic cmd, input logic [1:0] cnt,
                               input logic signed [COORD_IN_W-1:0] x,
                               input logic signed [COORD_IN_W-1:0] y,
                               input logic signed [COORD_IN_W-1:0] z);
        t_in_item it;
        it.cmd = cmd;
        it.coord_count = cnt;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        pending_points.push_back(it);
    endtask

    // Wait until every queued point is taken and every result is back, then let the block settle
    task automatic drain_points();
        while (pending_points.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_abs_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        abs_mode_model = mode;
    endtask

    // Track input acceptance for the driver
    always @(posedge i_clk)
        in_fire <= i_in_valid && o_in_ready;

    // Drive the input channel: hold the payload until accepted, idle at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data <= pending_points.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Hold off the receiver once for a long stretch to back up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && points_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Drive the output ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on each accepted point, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_result(i_in_data));
                points_taken <= points_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: az=%0d el=%0d dist=%0d",
                                 o_out_data.azimuth, o_out_data.elevation,
                                 o_out_data.distance);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_out_data.azimuth !== oldest_result.azimuth ||
                        o_out_data.elevation !== oldest_result.elevation ||
                        o_out_data.distance !== oldest_result.distance) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("exp az=%0d el=%0d dist=%0d got az=%0d el=%0d dist=%0d",
                                     oldest_result.azimuth, oldest_result.elevation,
                                     oldest_result.distance, o_out_data.azimuth,
                                     o_out_data.elevation, o_out_data.distance);
                    end
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 3; i++) begin
            cur_pt[i] = 0;
            prev_pt[i] = 0;
        end
        abs_mode_model = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 82;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_abs_mode(1'b0);

        // Directed: zero state, extremes, partial counts, axes, bit patterns
        queue_point(CMD_REPEAT, 2'd0, '0, '0, '0);
        queue_point(CMD_POINT, 2'd3, C_MIN, C_MIN, C_MIN);
        queue_point(CMD_POINT, 2'd3, C_MAX, C_MAX, C_MAX);
        queue_point(CMD_REPEAT, 2'd0, '0, '0, '0);
        queue_point(CMD_POINT, 2'd3, C_MIN, C_MIN, C_MIN);
        queue_point(CMD_POINT, 2'd0, C_MAX, C_MAX, C_MAX);
        queue_point(CMD_POINT, 2'd1, 32'sh0001_0000, C_MAX, C_MAX);
        queue_point(CMD_POINT, 2'd2, 32'sh0001_0000, 32'sh0002_0000, C_MAX);
        queue_point(CMD_POINT, 2'd3, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        queue_point(CMD_POINT, 2'd3, -32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        queue_point(CMD_POINT, 2'd3, -32'sh0001_0000, -32'sh0001_0000, 32'sh0003_0000);
        queue_point(CMD_POINT, 2'd3, '0, '0, '0);
        queue_point(CMD_POINT, 2'd3, 32'sd1, -32'sd1, 32'sd1);
        queue_point(CMD_POINT, 2'd3, 32'sd2, -32'sd2, -32'sd1);
        queue_point(CMD_POINT, 2'd3, 32'shA5A5_A5A5, 32'sh5A5A_5A5A, 32'shA5A5_A5A5);
        queue_point(CMD_POINT, 2'd3, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh5A5A_5A5A);
        queue_point(CMD_REPEAT, 2'd3, C_MAX, C_MIN, C_MAX);
        queue_point(CMD_POINT, 2'd3, C_MAX, '0, C_MIN);
        drain_points();

        // Random phases: alternate the origin mode and rotate the idle pattern
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_abs_mode((ph % 2) == 0);
            for (int n = 0; n < PHASE_POINTS; n++)
                pending_points.push_back(random_point());
            drain_points();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: point_delta_direction_speed.f
design/pdds_pkg.sv
design/point_delta_direction_speed.sv
test/tb_point_delta_direction_speed.sv
